[rtl/chm_pkg.sv]
// Package: types, constants and state codes of the chained hash map.
package chm_pkg;

	localparam int BUCKET_COUNT_DEF = 128;
	localparam int POOL_SIZE_DEF    = 256;
	localparam int KEY_WIDTH_DEF    = 32;
	localparam int VALUE_WIDTH_DEF  = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_ERASE  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key;
		logic [31:0] value;
	} chm_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] found_value;
		logic        full_res;
		logic [8:0]  entry_count;
	} chm_res_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_HEAD,
		ST_HEAD_WAIT,
		ST_NODE,
		ST_NODE_WAIT,
		ST_CMP,
		ST_FREE_WAIT,
		ST_COMMIT,
		ST_DONE
	} chm_state_t;

endpackage

[rtl/chm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/chained_hash_map_top.sv]
// Top level of the chained hash map: sequencer, bucket head and node pool memories and result register.
//
// Usage: drive req (mode, key, value) with start high while busy is low; the
// item is taken on that edge and busy rises. The block walks the bucket chain
// one node at a time through shared memories and a single key comparator.
// When done, done pulses for one cycle with res valid; the receiver cannot
// stall, so it must take res on that cycle. busy stays high through the done
// cycle and falls on the next one, when a new item may be taken.
// The walk runs the head read and its wait, then a node read and compare for
// each chain node visited, a free-list read for an insert of a new key, then
// commit and done. One item at a time: no new item is taken until the last
// one is done and busy falls.
// Reset: arst_n clears control state, the bucket valid bits and live count,
// then a pass over every pool entry chains the free list through the link
// memory; busy stays high during it and no item is taken.
// Keys above the bucket count hash by their low bits (power-of-two buckets).
// Mode 3 changes nothing and reports the live count.
module chained_hash_map_top
	import chm_pkg::*;
#(
	parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
	parameter int POOL_SIZE    = POOL_SIZE_DEF,
	parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
	parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  chm_req_t req,
	output logic     busy,
	output logic     done,
	output chm_res_t res
);

	localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam int LW = $clog2(POOL_SIZE + 1);
	localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

	chm_state_t state_q, state_d;

	logic [1:0]             mode_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [BW-1:0]          bkt_q;
	logic [LW-1:0]          cur_q, prev_q, free_q, nxt_q, steps_q, init_q;
	logic [LW-1:0]          count_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] fval_q;
	logic [BUCKET_COUNT-1:0] bvalid_q;

	logic          head_we;
	logic [PW-1:0] head_wdata, head_rdata;
	logic          key_we, val_we, link_we;
	logic [PW-1:0] node_waddr, node_raddr;
	logic [KEY_WIDTH-1:0]   key_rdata;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic [LW-1:0]          link_wdata, link_rdata;
	logic [LW-1:0]          link_waddr_full;

	logic [BW-1:0] req_bkt;
	logic          key_eq;
	logic          is_ins, is_era;

	assign req_bkt = (BUCKET_COUNT > 1) ? BW'(req.key[BW-1:0]) : '0;
	assign key_eq  = (key_rdata == key_q);
	assign is_ins  = (mode_q == MODE_INSERT);
	assign is_era  = (mode_q == MODE_ERASE);

	chm_ram #(.WIDTH(PW), .DEPTH(BUCKET_COUNT > 1 ? BUCKET_COUNT : 2)) u_head (
		.clk(clk), .we(head_we), .waddr(bkt_q), .wdata(head_wdata),
		.raddr(bkt_q), .rdata(head_rdata));
	chm_ram #(.WIDTH(KEY_WIDTH), .DEPTH(POOL_SIZE > 1 ? POOL_SIZE : 2)) u_key (
		.clk(clk), .we(key_we), .waddr(node_waddr), .wdata(key_q),
		.raddr(node_raddr), .rdata(key_rdata));
	chm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_SIZE > 1 ? POOL_SIZE : 2)) u_val (
		.clk(clk), .we(val_we), .waddr(node_waddr), .wdata(val_q),
		.raddr(node_raddr), .rdata(val_rdata));
	chm_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE > 1 ? POOL_SIZE : 2)) u_link (
		.clk(clk), .we(link_we), .waddr(node_waddr), .wdata(link_wdata),
		.raddr(node_raddr), .rdata(link_rdata));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT:      if (init_q == NIL - LW'(1)) state_d = ST_IDLE;
			ST_IDLE:      if (start) state_d = ST_HEAD;
			ST_HEAD:      state_d = ST_HEAD_WAIT;
			ST_HEAD_WAIT: state_d = bvalid_q[bkt_q] ? ST_NODE : ST_CMP;
			ST_NODE:      state_d = ST_NODE_WAIT;
			ST_NODE_WAIT: state_d = ST_CMP;
			ST_CMP: begin
				if (cur_q < NIL && !key_eq && steps_q < NIL - LW'(1) && link_rdata < NIL) begin
					state_d = ST_NODE_WAIT;
				end else if (is_ins && !(cur_q < NIL && key_eq) && free_q < NIL) begin
					state_d = ST_FREE_WAIT;
				end else begin
					state_d = ST_COMMIT;
				end
			end
			ST_FREE_WAIT: state_d = ST_COMMIT;
			ST_COMMIT:    state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory address and write control
	always_comb begin
		head_we         = 1'b0;
		head_wdata      = '0;
		key_we          = 1'b0;
		val_we          = 1'b0;
		link_we         = 1'b0;
		link_waddr_full = cur_q;
		link_wdata      = '0;
		node_raddr      = cur_q[PW-1:0];
		case (state_q)
			ST_INIT: begin
				link_we         = 1'b1;
				link_waddr_full = init_q;
				link_wdata      = init_q + LW'(1);
			end
			ST_HEAD_WAIT: node_raddr = head_rdata;
			ST_NODE:      node_raddr = cur_q[PW-1:0];
			ST_CMP: begin
				node_raddr = link_rdata[PW-1:0];
				if (!(cur_q < NIL && key_eq) && is_ins) begin
					node_raddr = free_q[PW-1:0];
				end
			end
			ST_COMMIT: begin
				if (is_ins && hit_q) begin
					val_we          = 1'b1;
					link_waddr_full = cur_q;
				end else if (is_ins && free_q < NIL) begin
					key_we          = 1'b1;
					val_we          = 1'b1;
					link_waddr_full = free_q;
					link_we         = 1'b1;
					link_wdata      = NIL;
					if (!(prev_q < NIL)) begin
						head_we    = 1'b1;
						head_wdata = free_q[PW-1:0];
					end
				end else if (is_era && hit_q) begin
					link_we         = 1'b1;
					link_waddr_full = cur_q;
					link_wdata      = free_q;
				end
			end
			ST_DONE: begin
				// append link of predecessor, or erase unlink
				if (is_ins && !hit_q && prev_q < NIL && res.full_res == 1'b0) begin
					link_we         = 1'b1;
					link_waddr_full = prev_q;
					link_wdata      = cur_q;
				end else if (is_era && hit_q && prev_q < NIL) begin
					link_we         = 1'b1;
					link_waddr_full = prev_q;
					link_wdata      = nxt_q;
				end else if (is_era && hit_q && nxt_q < NIL) begin
					head_we    = 1'b1;
					head_wdata = nxt_q[PW-1:0];
				end
			end
			default: ;
		endcase
	end

	assign node_waddr = link_waddr_full[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			init_q   <= '0;
			count_q  <= '0;
			free_q   <= '0;
			bvalid_q <= '0;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (state_q == ST_INIT) begin
				init_q <= init_q + LW'(1);
			end
			if (state_q == ST_COMMIT) begin
				done <= 1'b1;
				if (is_ins && !hit_q && free_q < NIL) begin
					free_q  <= nxt_q;
					count_q <= count_q + LW'(1);
					if (!(prev_q < NIL)) bvalid_q[bkt_q] <= 1'b1;
				end else if (is_era && hit_q) begin
					free_q <= cur_q;
					if (count_q != '0) count_q <= count_q - LW'(1);
					if (!(prev_q < NIL) && !(nxt_q < NIL)) bvalid_q[bkt_q] <= 1'b0;
				end
			end
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q  <= req.mode;
				key_q   <= KEY_WIDTH'(req.key);
				val_q   <= VALUE_WIDTH'(req.value);
				bkt_q   <= req_bkt;
				prev_q  <= NIL;
				cur_q   <= NIL;
				steps_q <= '0;
				hit_q   <= 1'b0;
				fval_q  <= '0;
			end
			ST_HEAD_WAIT: if (bvalid_q[bkt_q]) cur_q <= LW'(head_rdata);
			ST_CMP: begin
				if (cur_q < NIL && key_eq) begin
					hit_q  <= 1'b1;
					fval_q <= val_rdata;
					nxt_q  <= link_rdata;
				end else if (cur_q < NIL && steps_q < NIL - LW'(1) && link_rdata < NIL) begin
					prev_q  <= cur_q;
					cur_q   <= link_rdata;
					steps_q <= steps_q + LW'(1);
				end else if (cur_q < NIL) begin
					prev_q <= cur_q;
					cur_q  <= NIL;
				end
			end
			ST_FREE_WAIT: nxt_q <= link_rdata;
			ST_COMMIT: begin
				res.hit         <= hit_q && (mode_q != MODE_UNUSED);
				res.found_value <= (mode_q == MODE_FIND && hit_q) ? 32'(fval_q) : '0;
				res.full_res    <= is_ins && !hit_q && !(free_q < NIL);
				res.entry_count <= 9'((is_ins && !hit_q && free_q < NIL) ? count_q + LW'(1)
					: (is_era && hit_q && count_q != '0) ? count_q - LW'(1) : count_q);
				if (is_ins && !hit_q) cur_q <= free_q;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == ST_DONE) else $error("done outside done state");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LW'(POOL_SIZE)) else $error("live count overflow");
	a_full_ins: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.full_res |-> !res.hit) else $error("full with hit");

endmodule
